[rtl/core/b64e_pkg.sv]
// Shared types, constants and the character mapping for the base64 stream encoder.
// No dependencies; every other file in rtl/core refers to this package.
package b64e_pkg;

  localparam int QueueDepth = 2;

  localparam logic [6:0] PadChar = 7'h3D;   // '='
  localparam logic [6:0] UpperA  = 7'h41;   // 'A'
  localparam logic [6:0] LowerA  = 7'h61;   // 'a'
  localparam logic [6:0] Digit0  = 7'h30;   // '0'
  localparam logic [6:0] PlusChr = 7'h2B;   // '+'
  localparam logic [6:0] SlashCh = 7'h2F;   // '/'

  // One 24-bit group ready for encoding.
  typedef struct packed {
    logic [23:0] bits;    // first byte in 23:16
    logic [1:0]  pad;     // trailing '=' count (0..2)
    logic        last;    // group closes the message
  } group_t;

  function automatic logic [6:0] sextet_to_ascii(input logic [5:0] v);
    logic [6:0] c;
    if (v < 6'd26) begin
      c = UpperA + 7'(v);
    end else if (v < 6'd52) begin
      c = LowerA + 7'(v - 6'd26);
    end else if (v < 6'd62) begin
      c = Digit0 + 7'(v - 6'd52);
    end else if (v == 6'd62) begin
      c = PlusChr;
    end else begin
      c = SlashCh;
    end
    return c;
  endfunction

  // Character at position idx (0 = most significant sextet) of a group.
  function automatic logic [6:0] group_char(input group_t g, input logic [1:0] idx);
    logic [5:0] s;
    logic       is_pad;
    unique case (idx)
      2'd0: s = g.bits[23:18];
      2'd1: s = g.bits[17:12];
      2'd2: s = g.bits[11:6];
      2'd3: s = g.bits[5:0];
      default: s = g.bits[5:0];
    endcase
    is_pad = (3'(idx) + 3'(g.pad)) > 3'd3;
    return is_pad ? PadChar : sextet_to_ascii(s);
  endfunction

endpackage

[rtl/core/base64_stream_encoder_top.sv]
// Base64 stream encoder top level: front end, group queue, back end.
// The byte that closes a group goes into the queue, then into the back end's group register,
// then its first character goes into the output register. Throughput: one character per cycle
// while out_ready is high, set by the back end's single output register; a full group (3 bytes) gives four characters.
// Reset (rst, synchronous): clears held bytes, queue pointers and output valid.
// Depends on b64e_pkg, b64e_front, b64e_queue, b64e_back.
module base64_stream_encoder_top #(
  parameter int QDepth = b64e_pkg::QueueDepth
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       end_of_message,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] text_char,
  output logic       final_char
);

  b64e_pkg::group_t            push_data;
  b64e_pkg::group_t            pop_data;
  logic                        q_push;
  logic                        q_pop;
  logic                        q_empty;
  logic                        q_full;
  logic [$clog2(QDepth+1)-1:0] q_level;

  b64e_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .end_of_message (end_of_message),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (push_data)
  );

  b64e_queue #(.Depth(QDepth)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_data),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .empty     (q_empty),
    .full      (q_full),
    .level     (q_level)
  );

  b64e_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_data     (pop_data),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .text_char  (text_char),
    .final_char (final_char)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (!q_full || q_pop))
    else $error("group pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("group popped from an empty queue");

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    q_level <= ($clog2(QDepth+1))'(QDepth))
    else $error("queue level beyond depth");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(text_char) && $stable(final_char))
    else $error("character beat changed while stalled");

endmodule

[rtl/core/b64e_front.sv]
// Front end: accepts raw bytes, gathers them into 24-bit groups and pushes
// finished groups into the queue. Depends on b64e_pkg.
module b64e_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        data_byte,
  input  logic              end_of_message,
  input  logic              q_full,
  output logic              q_push,
  output b64e_pkg::group_t  q_data
);

  logic [15:0] held_bytes;
  logic [1:0]  held_count;
  logic        accept;
  logic        group_done;

  assign in_ready   = !q_full;
  assign accept     = in_valid && in_ready;
  assign group_done = (held_count >= 2'd2) || end_of_message;
  assign q_push     = accept && group_done;

  always_comb begin
    q_data.last = end_of_message;
    priority if (held_count >= 2'd2) begin
      q_data.bits = {held_bytes, data_byte};
      q_data.pad  = 2'd0;
    end else if (held_count == 2'd1) begin
      q_data.bits = {held_bytes[7:0], data_byte, 8'h00};
      q_data.pad  = 2'd1;
    end else begin
      q_data.bits = {data_byte, 16'h0000};
      q_data.pad  = 2'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_bytes <= '0;
      held_count <= '0;
    end else if (accept) begin
      if (group_done) begin
        held_bytes <= '0;
        held_count <= '0;
      end else begin
        held_bytes <= {held_bytes[7:0], data_byte};
        held_count <= held_count + 2'd1;
      end
    end
  end

endmodule

[rtl/core/b64e_queue.sv]
// Small register queue of pending groups between front and back end.
// Depends on b64e_pkg.
module b64e_queue #(
  parameter int Depth = b64e_pkg::QueueDepth
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  b64e_pkg::group_t         push_data,
  input  logic                     pop,
  output b64e_pkg::group_t         pop_data,
  output logic                     empty,
  output logic                     full,
  output logic [$clog2(Depth+1)-1:0] level
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  b64e_pkg::group_t mem [Depth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;

  assign empty    = (count == '0);
  assign full     = (count == CntW'(Depth));
  assign level    = count;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CntW'(1);
        2'b01:   count <= count - CntW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/core/b64e_back.sv]
// Back end: takes one group from the queue and sends its four characters,
// one beat per cycle while out_ready is high, from a registered output stage. Depends on b64e_pkg.
module b64e_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  b64e_pkg::group_t  q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [6:0]        text_char,
  output logic              final_char
);

  b64e_pkg::group_t cur;
  logic             busy;
  logic [1:0]       idx;
  logic             load;
  logic             finishing;

  assign load      = !out_valid || out_ready;
  assign finishing = busy && load && (idx == 2'd3);
  assign q_pop     = (!busy || finishing) && !q_empty;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
    if (load && busy) begin
      text_char  <= b64e_pkg::group_char(cur, idx);
      final_char <= cur.last && (idx == 2'd3);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= busy;
      end
      if (q_pop) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (load && busy) begin
        // advance; drop busy after the fourth character
        idx <= idx + 2'd1;
        if (idx == 2'd3) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

[bench/base64_char_checker.sv]
// Scoreboard for the base64 stream encoder: predicts the characters of every accepted byte
// beat and compares them with the character beats that leave the block.
// Depends on b64e_pkg for the pad code.
module base64_char_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       end_of_message,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [6:0] text_char,
  input  logic       final_char,
  output int         fails,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [6:0] code;
    logic       last;
  } enc_char_t;

  // Standard alphabet, sextet 0 in the top byte.
  localparam logic [511:0] Alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic [15:0] open_bytes;
  logic [1:0]  open_count;
  enc_char_t   char_q[$];

  function automatic logic [6:0] sextet_char(input logic [5:0] s);
    return Alphabet[8 * (63 - int'(s)) +: 7];
  endfunction

  task automatic encode_byte(input logic [7:0] b, input logic eom);
    logic [23:0] grp;
    int          n_real;
    enc_char_t   c;
    if (open_count == 2'd2) begin
      grp    = {open_bytes, b};
      n_real = 4;
    end else if (!eom) begin
      // hold the byte until the group fills or the message ends
      open_bytes = {open_bytes[7:0], b};
      open_count = open_count + 2'd1;
      return;
    end else if (open_count == 2'd0) begin
      grp    = {b, 16'h0000};
      n_real = 2;
    end else begin
      grp    = {open_bytes[7:0], b, 8'h00};
      n_real = 3;
    end
    for (int k = 0; k < 4; k++) begin
      c.code = (k < n_real) ? sextet_char(grp[23 - 6 * k -: 6]) : b64e_pkg::PadChar;
      c.last = (k == 3) && eom;
      char_q.push_back(c);
    end
    open_bytes = '0;
    open_count = '0;
  endtask

  always @(posedge clk) begin
    enc_char_t want;
    if (rst) begin
      open_bytes = '0;
      open_count = '0;
      char_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (char_q.size() == 0) begin
          $display("%0t: unexpected character beat %h final %0b", $time, text_char, final_char);
          fails++;
        end else begin
          want = char_q.pop_front();
          if (text_char !== want.code) begin
            $display("%0t: text_char expected %h got %h", $time, want.code, text_char);
            fails++;
          end
          if (final_char !== want.last) begin
            $display("%0t: final_char expected %0b got %0b", $time, want.last, final_char);
            fails++;
          end
        end
      end
      if (in_valid && in_ready) begin
        encode_byte(data_byte, end_of_message);
      end
    end
    pending = char_q.size();
  end

endmodule

[bench/tb_base64_stream_encoder_top.sv]
// Top of the base64 encoder bench: drives byte beats and output back-pressure,
// instantiates base64_stream_encoder_top and base64_char_checker, and gives the verdict.
// Depends on b64e_pkg, the encoder RTL and bench/base64_char_checker.sv.
module tb_base64_stream_encoder_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HoldCycles = 200;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] data_byte;
  logic       end_of_message;
  logic       out_valid;
  logic       out_ready;
  logic [6:0] text_char;
  logic       final_char;
  int         fails;
  int         pending;

  bit send_gaps;
  bit recv_gaps;
  int holds_asked;
  int holds_done;
  int hold_left;
  int stall_left;
  int bytes_sent;
  int msgs_sent;
  int grp_pos;
  int tails[3];

  base64_stream_encoder_top dut (.*);
  base64_char_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Output side: random stall bursts, plus long holds on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_asked != holds_done) begin
        holds_done++;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else if (recv_gaps && $urandom_range(0, 7) == 0) begin
        out_ready  = 1'b0;
        stall_left = $urandom_range(0, 17);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eom);
    @(negedge clk);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid       = 1'b1;
    data_byte      = b;
    end_of_message = eom;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    if (eom) begin
      tails[grp_pos]++;
      msgs_sent++;
      grp_pos = 0;
    end else begin
      grp_pos = (grp_pos + 1) % 3;
    end
  endtask

  task automatic send_message(input int len);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 9))
        0:       b = 8'h00;
        1:       b = 8'hFF;
        default: b = 8'($urandom_range(0, 255));
      endcase
      send_byte(b, i == len - 1);
    end
  endtask

  task automatic send_until(input int target);
    int len;
    while (bytes_sent < target) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 30) : $urandom_range(1, 10);
      // clip the last message so the byte count lands on the target
      if (len > target - bytes_sent) begin
        len = target - bytes_sent;
      end
      send_message(len);
    end
  endtask

  initial begin
    in_valid       = 1'b0;
    data_byte      = 8'h00;
    end_of_message = 1'b0;
    rst            = 1'b1;
    send_gaps      = 1'b1;
    recv_gaps      = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // lone byte, two-byte and three-byte messages, all-zero and all-one data
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    // '+' and '/' groups mid-message, then a full closing group and a two-byte message
    send_byte(8'hFB, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBE, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h4D, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h6E, 1'b1);
    send_byte(8'h66, 1'b0);
    send_byte(8'h6F, 1'b1);

    send_until(130);

    // drain completely before the next phase
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);

    // long output hold while input keeps coming, so the block backs up
    @(posedge clk);
    send_gaps = 1'b0;
    holds_asked++;
    send_until(bytes_sent + 45);
    send_gaps = 1'b1;

    send_until(230);

    // final stretch with no idling on either side
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    send_until(272);

    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("Encoded %0d messages from %0d bytes; one/two/three-byte tails: %0d/%0d/%0d",
             msgs_sent, bytes_sent, tails[0], tails[1], tails[2]);
    $display("Covered random stalls, a %0d-cycle output hold and a full drain pause",
             HoldCycles);
    if (fails == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
